// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for the load balancer RTL, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define FALB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define FALB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define FALB_ASSERT(lbl, prop, msg)
`define FALB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/falb_pkg.sv =====
// ---------------------------------------------------------------------------
// Flow affinity load balancer package
// Shared constants, word formats and controller/datapath signal groups.
// ---------------------------------------------------------------------------
`default_nettype none

package falb_pkg;

    localparam int FLOW_ENTRIES    = 64;
    localparam int IDX_W           = $clog2(FLOW_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    localparam int POOL_SIZE       = 4;
    localparam int NUM_SERVER_REGS = 4;
    localparam int RR_W            = 2;
    localparam logic [RR_W:0] POOL_SIZE_W = (RR_W + 1)'(POOL_SIZE);

    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS = CFG_IDX_W'(NUM_SERVER_REGS);

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] FLAGS_SYN = 8'd2;

    typedef enum logic [1:0] {
        VERDICT_FORWARD   = 2'd0,
        VERDICT_HELD      = 2'd1,
        VERDICT_UNHANDLED = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  ip_proto;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [7:0]  tcp_flag_bits;
    } lb_in_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] new_dst_ip;
        logic        flow_stored;
        logic        table_full;
    } lb_out_t;

    typedef struct packed {
        logic [63:0] addr_key;
        logic [39:0] port_key;
        logic [31:0] server;
    } flow_entry_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } lb_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } lb_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/falb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Load balancer controller
// Sequences word intake, the flow table scan and the result commit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module falb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire falb_pkg::lb_sts_t sts,
    output falb_pkg::lb_cmd_t     cmd
);
    import falb_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.scan_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
            end
            ST_FINISH: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    `FALB_ASSERT(a_accept_starts_scan, s_valid && s_ready |=> state_reg == ST_SCAN, "accepted word did not start a scan")
    `FALB_ASSERT(a_commit_returns_idle, cmd.commit |=> state_reg == ST_IDLE, "commit did not return to idle")

endmodule

`default_nettype wire

// ===== rtl/core/falb_datapath.sv =====
// ---------------------------------------------------------------------------
// Load balancer datapath
// Flow table memory, sequential exact-match scan, round robin and result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module falb_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire falb_pkg::lb_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output falb_pkg::lb_out_t                        m_data,
    input  wire logic                                cfg_we,
    input  wire logic [falb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [falb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire falb_pkg::lb_cmd_t                   cmd,
    output falb_pkg::lb_sts_t                        sts
);
    import falb_pkg::*;

    flow_entry_t flow_mem [FLOW_ENTRIES];

    logic [FLOW_ENTRIES-1:0] valid_reg;
    logic [31:0]             server_addr_reg [NUM_SERVER_REGS];
    logic [RR_W-1:0]         rr_reg;

    lb_in_t                  item_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    rd_more_reg;
    logic                    cmp_act_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    flow_entry_t             mem_q_reg;
    logic                    done_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        found_idx_reg;
    logic [31:0]             found_srv_reg;
    logic                    free_ok_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    lb_out_t                 out_reg;
    logic                    m_valid_reg;

    logic [63:0]      item_akey;
    logic [39:0]      item_pkey;
    logic             is_tcp;
    logic             is_syn;
    logic             rd_en;
    logic             key_match;
    logic [RR_W-1:0]  slot;
    logic [RR_W-1:0]  slot_next;
    logic [31:0]      server_sel;
    logic             store_ok;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    flow_entry_t      wr_entry;
    lb_out_t          result;

    assign item_akey = {item_reg.src_ip, item_reg.dst_ip};
    assign item_pkey = {item_reg.l4_sport, item_reg.l4_dport, item_reg.ip_proto};
    assign is_tcp    = (item_reg.ip_proto == PROTO_TCP);
    assign is_syn    = is_tcp && (item_reg.tcp_flag_bits == FLAGS_SYN);

    assign rd_en     = cmd.step && rd_more_reg && !done_reg;
    assign key_match = valid_reg[cmp_idx_reg] && (mem_q_reg.addr_key == item_akey)
                       && (mem_q_reg.port_key == item_pkey);

    // A stale round robin value at or above the pool size falls back to slot zero.
    assign slot       = ({1'b0, rr_reg} >= POOL_SIZE_W) ? '0 : rr_reg;
    assign slot_next  = (({1'b0, slot} + (RR_W + 1)'(1)) >= POOL_SIZE_W) ? '0
                        : slot + RR_W'(1);
    assign server_sel = server_addr_reg[slot];

    assign store_ok = found_reg || free_ok_reg;
    assign wr_en    = cmd.commit && is_syn && store_ok;
    assign wr_idx   = found_reg ? found_idx_reg : free_idx_reg;
    assign wr_entry = '{addr_key: item_akey, port_key: item_pkey, server: server_sel};

    always_comb begin
        result = '{verdict: VERDICT_UNHANDLED, new_dst_ip: '0,
                   flow_stored: 1'b0, table_full: 1'b0};
        if (is_syn) begin
            result.verdict     = VERDICT_FORWARD;
            result.new_dst_ip  = server_sel;
            result.flow_stored = store_ok;
            result.table_full  = !store_ok;
        end else if (is_tcp) begin
            if (found_reg) begin
                result.verdict    = VERDICT_FORWARD;
                result.new_dst_ip = found_srv_reg;
            end else begin
                result.verdict = VERDICT_HELD;
            end
        end
    end

    // Flow table memory: one write port at commit, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            flow_mem[wr_idx] <= wr_entry;
        end
        if (rd_en) begin
            mem_q_reg <= flow_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            rr_reg      <= '0;
            for (int i = 0; i < NUM_SERVER_REGS; i++) begin
                server_addr_reg[i] <= '0;
            end
            rd_idx_reg  <= '0;
            rd_more_reg <= 1'b0;
            cmp_act_reg <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index < CFG_NUM_REGS)) begin
                server_addr_reg[cfg_index[RR_W-1:0]] <= cfg_data;
            end

            if (cmd.load) begin
                rd_idx_reg  <= '0;
                rd_more_reg <= 1'b1;
                cmp_act_reg <= 1'b0;
                done_reg    <= 1'b0;
                found_reg   <= 1'b0;
                free_ok_reg <= 1'b0;
            end else if (cmd.step) begin
                if (!is_tcp) begin
                    done_reg <= 1'b1;
                end
                if (rd_en) begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == LAST_IDX) rd_more_reg <= 1'b0;
                end
                cmp_act_reg <= rd_en;
                // The compare stage works on the address read in the cycle before.
                if (cmp_act_reg && !done_reg) begin
                    if (key_match) begin
                        found_reg <= 1'b1;
                        done_reg  <= 1'b1;
                    end else begin
                        if (!valid_reg[cmp_idx_reg] && !free_ok_reg) free_ok_reg <= 1'b1;
                        if (cmp_idx_reg == LAST_IDX) done_reg <= 1'b1;
                    end
                end
            end

            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit && is_syn) begin
                rr_reg <= slot_next;
            end

            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the scan and the output word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.step) begin
            cmp_idx_reg <= rd_idx_reg;
            if (cmp_act_reg && !done_reg) begin
                if (key_match) begin
                    found_idx_reg <= cmp_idx_reg;
                    found_srv_reg <= mem_q_reg.server;
                end else if (!valid_reg[cmp_idx_reg] && !free_ok_reg) begin
                    free_idx_reg <= cmp_idx_reg;
                end
            end
        end
        if (cmd.commit) begin
            out_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign sts.scan_done = done_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    `FALB_ASSERT(a_stored_or_full, m_valid |-> !(m_data.flow_stored && m_data.table_full), "flow stored and table full both set")
    `FALB_ASSERT(a_store_sets_valid, wr_en |=> valid_reg[$past(wr_idx)], "stored flow entry not marked valid")
    `FALB_ASSERT(a_done_holds, done_reg && !cmd.load |=> done_reg, "scan done dropped before next word")
    `FALB_ASSERT(a_commit_needs_free, cmd.commit |-> sts.out_free, "result committed over a waiting word")

endmodule

`default_nettype wire

// ===== rtl/core/flow_affinity_load_balancer.sv =====
// ---------------------------------------------------------------------------
// Flow affinity load balancer
// Layer-4 load balancer: SYN picks a backend round robin and records the
// flow; later TCP words of a flow are steered to the recorded backend.
// ---------------------------------------------------------------------------
//  Channel  Ports                               Direction  Word
//  s_       s_valid s_ready s_data              in         falb_pkg::lb_in_t
//  m_       m_valid m_ready m_data              out        falb_pkg::lb_out_t
//  cfg_     cfg_we cfg_index cfg_data           in         server address write
//
// One word is in work at a time. A non-TCP word does not search the table; a
// TCP word scans the flow table one entry per cycle through the single read
// port of the table memory and stops at the first hit or after the last entry.
// A new word is accepted while the previous result waits in the output
// register; a stalled output delays only the commit. Reset is synchronous and
// clears the valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module flow_affinity_load_balancer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire falb_pkg::lb_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output falb_pkg::lb_out_t                        m_data,
    input  wire logic                                cfg_we,
    input  wire logic [falb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [falb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import falb_pkg::*;

    lb_cmd_t cmd;
    lb_sts_t sts;

    falb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    falb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
